@@ sv/rau_pkg.sv @@
package rau_pkg;

    // operand width as read from each input field
    localparam int VALUE_WIDTH = 16;
    localparam int IN_W        = 16;
    localparam int OP_W        = 4;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int SUM_W       = PROD_W + 1;
    localparam int MAG_W       = PROD_W;
    localparam int NUM_W       = 33;
    localparam int DEN_W       = 31;
    localparam int IN_DATA_W   = 4 * IN_W;
    localparam int OUT_DATA_W  = 72;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_LE  = 4'd5,
        OP_GT  = 4'd6,
        OP_GE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9
    } t_op;

endpackage

@@ sv/rau_gcd.sv @@
module rau_gcd (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rau_pkg::MAG_W-1:0] i_a,
    input  logic [rau_pkg::MAG_W-1:0] i_b,
    output logic                      o_done,
    output logic [rau_pkg::MAG_W-1:0] o_gcd
);
    import rau_pkg::*;

    localparam int K_W = $clog2(MAG_W + 1);

    typedef enum logic [1:0] {G_IDLE, G_STRIP, G_LOOP} t_state;

    t_state             r_state;
    logic [MAG_W-1:0]   r_a;
    logic [MAG_W-1:0]   r_b;
    logic [K_W-1:0]     r_k;
    logic               r_done;
    logic [MAG_W-1:0]   r_gcd;

    // binary gcd: strip common twos, then odd/odd subtract and halve
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_k     <= '0;
                        r_state <= G_STRIP;
                    end
                end
                G_STRIP: begin
                    if (r_a[0] || r_b[0]) begin
                        r_state <= G_LOOP;
                    end else begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end
                end
                G_LOOP: begin
                    if (r_a == '0) begin
                        r_gcd   <= r_b << r_k;
                        r_done  <= 1'b1;
                        r_state <= G_IDLE;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= (r_a - r_b) >> 1;
                    end else begin
                        r_b <= (r_b - r_a) >> 1;
                    end
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_gcd;

endmodule

@@ sv/rau_div.sv @@
module rau_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rau_pkg::MAG_W-1:0] i_dividend,
    input  logic [rau_pkg::MAG_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rau_pkg::MAG_W-1:0] o_quotient
);
    import rau_pkg::*;

    localparam int C_W = $clog2(MAG_W + 1);

    typedef enum logic {D_IDLE, D_RUN} t_state;

    t_state             r_state;
    logic [MAG_W-1:0]   r_rem;
    logic [MAG_W-1:0]   r_q;
    logic [MAG_W-1:0]   r_d;
    logic [C_W-1:0]     r_cnt;
    logic               r_done;
    logic [MAG_W:0]     trial;
    logic               fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_q[MAG_W-1]};
    assign fits  = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_q     <= i_dividend;
                        r_d     <= i_divisor;
                        r_cnt   <= C_W'(MAG_W);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= fits ? MAG_W'(trial - {1'b0, r_d}) : trial[MAG_W-1:0];
                    r_q   <= {r_q[MAG_W-2:0], fits};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == C_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ sv/rational_arithmetic_unit.sv @@
// errors and unused codes go straight to the result; comparisons and zero results
//   finish after the products and the sum; add, sub, mul and div also pass through
//   the binary gcd and two serial divides
// throughput: one item at a time, the next transfer is taken only once the result
//   register has loaded and the sequencer is back in idle
// reset: i_rst_n synchronous active low, returns the sequencer to idle, no result pending
module rational_arithmetic_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_numerator, first_denominator, second_numerator, second_denominator
    input  logic [rau_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [rau_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result_numerator, result_denominator, compare_true, zero pad
    output logic [rau_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // error
    output logic                           m_axis_tuser
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_GCD, S_DIVN, S_DIVD, S_DONE
    } t_state;

    t_state                     r_state;
    t_op                        r_op;
    logic signed [VALUE_WIDTH-1:0] r_n1, r_d1, r_n2, r_d2;
    logic [1:0]                 r_cnt;
    logic signed [PROD_W-1:0]   r_p0, r_p1, r_p2;
    logic [MAG_W-1:0]           r_num_mag;
    logic [MAG_W-1:0]           r_den_mag;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_g;
    logic [MAG_W-1:0]           r_q_num;
    logic                       r_gcd_start;
    logic                       r_div_start;
    // result held until the output register is free
    logic [NUM_W-1:0]           r_res_num;
    logic [DEN_W-1:0]           r_res_den;
    logic                       r_res_cmp;
    logic                       r_res_err;
    // output register
    logic                       r_o_valid;
    logic [NUM_W-1:0]           r_o_num;
    logic [DEN_W-1:0]           r_o_den;
    logic                       r_o_cmp;
    logic                       r_o_err;

    // input fields, read as VALUE_WIDTH-bit two's complement
    logic [OP_W-1:0]               in_op;
    logic signed [VALUE_WIDTH-1:0] in_n1, in_d1, in_n2, in_d2;
    logic                          in_err;
    logic                          in_accept;

    assign in_op  = s_axis_tuser;
    assign in_n1  = VALUE_WIDTH'(s_axis_tdata[IN_W-1:0]);
    assign in_d1  = VALUE_WIDTH'(s_axis_tdata[2*IN_W-1:IN_W]);
    assign in_n2  = VALUE_WIDTH'(s_axis_tdata[3*IN_W-1:2*IN_W]);
    assign in_d2  = VALUE_WIDTH'(s_axis_tdata[4*IN_W-1:3*IN_W]);
    assign in_err = (in_d1 == '0) || (in_d2 == '0) ||
                    (in_op == OP_DIV && in_n2 == '0);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // shared multiplier: three products, selected by r_cnt in S_MUL
    // cnt 0: n1*d2 (n1*n2 for mul), cnt 1: n2*d1, cnt 2: d1*d2 (d1*n2 for div)
    logic signed [VALUE_WIDTH-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]      mul_p;

    always_comb begin
        case (r_cnt)
            2'd0:    mul_a = r_n1;
            2'd1:    mul_a = r_n2;
            default: mul_a = r_d1;
        endcase
        case (r_cnt)
            2'd0:    mul_b = (r_op == OP_MUL) ? r_n2 : r_d2;
            2'd1:    mul_b = r_d1;
            default: mul_b = (r_op == OP_DIV) ? r_n2 : r_d2;
        endcase
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // numerator and denominator before reduction
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        sum_abs;
    logic [PROD_W-1:0]       den_abs;
    logic                    sum_neg;
    logic                    sum_zero;
    logic                    frac_neg;
    logic                    cmp_val;

    always_comb begin
        case (r_op)
            OP_ADD:         sum = SUM_W'(r_p0) + SUM_W'(r_p1);
            OP_MUL, OP_DIV: sum = SUM_W'(r_p0);
            default:        sum = SUM_W'(r_p0) - SUM_W'(r_p1);
        endcase
    end
    assign sum_neg  = sum[SUM_W-1];
    assign sum_zero = (sum == '0);
    assign sum_abs  = sum_neg ? -sum : sum;
    assign den_abs  = r_p2[PROD_W-1] ? -r_p2 : r_p2;
    assign frac_neg = !sum_zero && (sum_neg != r_p2[PROD_W-1]);

    // sign tests of the difference
    always_comb begin
        case (r_op)
            OP_LT:   cmp_val = frac_neg;
            OP_LE:   cmp_val = frac_neg || sum_zero;
            OP_GT:   cmp_val = !frac_neg && !sum_zero;
            OP_GE:   cmp_val = !frac_neg;
            OP_EQ:   cmp_val = sum_zero;
            default: cmp_val = !sum_zero;
        endcase
    end

    // reduction units
    logic             gcd_done;
    logic [MAG_W-1:0] gcd_val;
    logic             div_done;
    logic [MAG_W-1:0] div_q;
    logic [MAG_W-1:0] div_dividend;

    assign div_dividend = (r_state == S_DIVD) ? r_den_mag : r_num_mag;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_gcd_start),
        .i_a     (r_num_mag),
        .i_b     (r_den_mag),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_g),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    logic out_free;
    assign out_free = !r_o_valid || m_axis_tready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_gcd_start <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_gcd_start <= 1'b0;
            r_div_start <= 1'b0;
            // in S_DONE the load below takes care of the output register
            if (r_o_valid && m_axis_tready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_op      <= t_op'(in_op);
                        r_n1      <= in_n1;
                        r_d1      <= in_d1;
                        r_n2      <= in_n2;
                        r_d2      <= in_d2;
                        r_cnt     <= 2'd0;
                        r_res_num <= '0;
                        r_res_den <= DEN_W'(1);
                        r_res_cmp <= 1'b0;
                        r_res_err <= 1'b0;
                        // unused codes and errors finish at once as 0/1
                        if (in_op > OP_NE) begin
                            r_state <= S_DONE;
                        end else if (in_err) begin
                            r_res_err <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    case (r_cnt)
                        2'd0:    r_p0 <= mul_p;
                        2'd1:    r_p1 <= mul_p;
                        default: r_p2 <= mul_p;
                    endcase
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd2) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_num_mag <= sum_abs[MAG_W-1:0];
                    r_den_mag <= den_abs;
                    r_neg     <= frac_neg;
                    if (r_op > OP_DIV) begin
                        r_res_cmp <= cmp_val;
                        r_state   <= S_DONE;
                    end else if (sum_zero) begin
                        // zero reduces to 0/1
                        r_state <= S_DONE;
                    end else begin
                        r_gcd_start <= 1'b1;
                        r_state     <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (gcd_done) begin
                        r_g         <= gcd_val;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    if (div_done) begin
                        r_q_num     <= div_q;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (div_done) begin
                        r_res_num <= r_neg ? -NUM_W'(r_q_num) : NUM_W'(r_q_num);
                        r_res_den <= DEN_W'(div_q);
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_num   <= r_res_num;
                        r_o_den   <= r_res_den;
                        r_o_cmp   <= r_res_cmp;
                        r_o_err   <= r_res_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - NUM_W - DEN_W - 1){1'b0}},
                            r_o_cmp, r_o_den, r_o_num};
    assign m_axis_tuser  = r_o_err;

    // an accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input taken while busy");

    // an error result is always 0/1 with no compare outcome
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_err) |-> (r_o_num == '0 && r_o_den == DEN_W'(1) && !r_o_cmp))
        else $error("error result not 0/1");

    // a compare outcome never comes with a nonzero numerator
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_cmp) |-> (r_o_num == '0 && r_o_den == DEN_W'(1)))
        else $error("compare result carries a fraction");

    // the reduced denominator is never zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_den != '0))
        else $error("zero denominator out");

    // the gcd used for the divides is never zero
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_g != '0))
        else $error("divide by zero gcd");

endmodule

@@ tb/rau_checker.sv @@
module rau_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [rau_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [rau_pkg::OP_W-1:0]       i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [rau_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_items,
    output int                             o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             cmp;
        logic             err;
    } t_fraction_out;

    t_fraction_out reduced_q[$];

    function automatic longint gcd_of(longint a, longint b);
        longint t;
        while (a != 0) begin
            t = a;
            a = b % a;
            b = t;
        end
        return b;
    endfunction

    function automatic t_fraction_out reduce_fraction(logic [OP_W-1:0] op,
                                                      logic [IN_DATA_W-1:0] d);
        t_fraction_out r;
        longint n1, d1, n2, d2, num, den, g, rn, rd;
        logic neg, zero, c;
        n1 = longint'($signed(d[15:0]));
        d1 = longint'($signed(d[31:16]));
        n2 = longint'($signed(d[47:32]));
        d2 = longint'($signed(d[63:48]));
        r = '{num: '0, den: DEN_W'(1), cmp: 1'b0, err: 1'b0};
        if (op > OP_NE) return r;
        if (d1 == 0 || d2 == 0 || (op == OP_DIV && n2 == 0)) begin
            r.err = 1'b1;
            return r;
        end
        case (op)
            OP_MUL: begin
                num = n1 * n2;
                den = d1 * d2;
            end
            OP_DIV: begin
                num = n1 * d2;
                den = d1 * n2;
            end
            OP_ADD: begin
                num = n1 * d2 + n2 * d1;
                den = d1 * d2;
            end
            default: begin
                num = n1 * d2 - n2 * d1;
                den = d1 * d2;
            end
        endcase
        // denominator sign folds into the numerator
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        g = gcd_of(num < 0 ? -num : num, den);
        if (g == 0) g = 1;
        rn = num / g;
        rd = den / g;
        if (op <= OP_DIV) begin
            r.num = rn[NUM_W-1:0];
            r.den = rd[DEN_W-1:0];
        end else begin
            neg  = rn < 0;
            zero = rn == 0;
            case (op)
                OP_LT:   c = neg;
                OP_LE:   c = neg || zero;
                OP_GT:   c = !neg && !zero;
                OP_GE:   c = !neg;
                OP_EQ:   c = zero;
                default: c = !zero;
            endcase
            r.cmp = c;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = reduced_q.size();

    always @(posedge i_clk) begin
        t_fraction_out want;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            reduced_q.push_back(reduce_fraction(i_s_tuser, i_s_tdata));
            o_items++;
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            o_results++;
            if (reduced_q.size() == 0) begin
                report_mismatch("unexpected transfer", i_m_tdata[63:0], 0);
            end else begin
                want = reduced_q.pop_front();
                if (i_m_tdata[32:0] !== want.num)
                    report_mismatch("numerator", i_m_tdata[32:0], want.num);
                if (i_m_tdata[63:33] !== want.den)
                    report_mismatch("denominator", i_m_tdata[63:33], want.den);
                if (i_m_tdata[64] !== want.cmp)
                    report_mismatch("compare", i_m_tdata[64], want.cmp);
                if (i_m_tuser !== want.err)
                    report_mismatch("error", i_m_tuser, want.err);
            end
        end
    end
endmodule

@@ tb/rational_arithmetic_unit_test.sv @@
module rational_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // first_numerator, first_denominator, second_numerator, second_denominator
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // operation
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // result_numerator, result_denominator, compare_true, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // error
    logic                  m_axis_tuser;

    int fail_count, pending, items, results;
    int burst_left;

    rational_arithmetic_unit uut (.*);

    rau_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_items     (items),
        .o_results   (results)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // receiver: alternates between always-ready, light and heavy stall stretches
    always @(posedge i_clk) begin
        int mode_cnt;
        int mode;
        if (mode_cnt == 0) begin
            mode_cnt = $urandom_range(50, 400);
            mode = $urandom_range(0, 2);
        end
        mode_cnt--;
        case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [15:0] any_value();
        int r;
        r = $urandom_range(0, 7);
        if (r < 4) return 16'($signed($urandom_range(0, 40)) - 20);   // small, reduces often
        if (r == 4) return 16'h8000;
        if (r == 5) return 16'h7fff;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] nonzero_den();
        logic [15:0] v;
        v = any_value();
        return (v == 0) ? 16'd1 : v;
    endfunction

    // one transfer on the input side, then maybe a gap that ends the burst
    task automatic send_fraction_pair(logic [OP_W-1:0] op, logic [15:0] n1, logic [15:0] d1,
                                      logic [15:0] n2, logic [15:0] d2);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {d2, n2, d1, n1};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 30);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        int wait_cnt;
        logic [OP_W-1:0] op;
        burst_left    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each operation, extremes, zero denominators, zero divisor, unused codes
        send_fraction_pair(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_fraction_pair(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_fraction_pair(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fraction_pair(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_fraction_pair(OP_ADD, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
        send_fraction_pair(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_fraction_pair(OP_ADD, 16'd0, 16'hffff, 16'd0, 16'd5);
        send_fraction_pair(OP_MUL, 16'd6, 16'hfffc, 16'hfffd, 16'd9);
        send_fraction_pair(OP_LT, 16'd1, 16'd3, 16'd1, 16'd2);
        send_fraction_pair(OP_LE, 16'd2, 16'd4, 16'd1, 16'd2);
        send_fraction_pair(OP_GT, 16'hffff, 16'd2, 16'd1, 16'hfffe);
        send_fraction_pair(OP_GE, 16'h8000, 16'd1, 16'h7fff, 16'd1);
        send_fraction_pair(OP_EQ, 16'd3, 16'd6, 16'hffff, 16'hfffe);
        send_fraction_pair(OP_NE, 16'd3, 16'd6, 16'd1, 16'd2);
        send_fraction_pair(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);      // zero left denominator
        send_fraction_pair(OP_EQ, 16'd1, 16'd1, 16'd1, 16'd0);       // zero right denominator
        send_fraction_pair(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);      // division by zero
        send_fraction_pair(OP_MUL, 16'd5, 16'd7, 16'd0, 16'd3);
        send_fraction_pair(4'd10, 16'd1, 16'd1, 16'd1, 16'd1);       // unused codes
        send_fraction_pair(4'd15, 16'hffff, 16'd0, 16'hffff, 16'hffff);

        // random: mostly valid operations with nonzero denominators
        repeat (800) begin
            case ($urandom_range(0, 19))
                0:       op = 4'($urandom_range(10, 15));
                default: op = 4'($urandom_range(0, 9));
            endcase
            if ($urandom_range(0, 19) == 0)
                send_fraction_pair(op, any_value(), any_value(), any_value(), any_value());
            else
                send_fraction_pair(op, any_value(), nonzero_den(), any_value(), nonzero_den());
        end
        s_axis_tvalid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (300) @(posedge i_clk);

        $display("covered %0d input transfers and %0d result transfers", items, results);
        $display("all ten operations, unused codes, zero denominators and zero divisors");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
